/* design/fsws_pkg.sv */
// Shared types, widths and constants of the Fourier-series waveform synthesizer.
package fsws_pkg;

	localparam int FS_W = 18;
	localparam int HC_W = 7;
	localparam int CMD_W = 2;
	localparam int N_W = 32;
	localparam int F_W = 24;
	localparam int OUT_W = 20;
	localparam int PHASE_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam int DEF_MAX_HARMONICS = 64;
	localparam int DEF_SINE_TABLE_DEPTH = 1024;

	localparam logic [FS_W-1:0] FS_RESET = 18'd20000;
	localparam logic [HC_W-1:0] HC_RESET = 7'd50;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLING_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HARMONIC_COUNT = 2'd1;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	// Phase division: 56 product bits and 32 fraction bits.
	localparam int PROD_W = N_W + F_W;
	localparam int DIVIDEND_W = PROD_W + PHASE_W;
	localparam int DIV_CNT_W = $clog2(DIVIDEND_W);
	localparam int DEN_W = FS_W + 8;

	localparam int MAG_W = 17;
	localparam int RECIP_SHIFT = 34;
	localparam int RECIP_W = RECIP_SHIFT + 1;
	localparam int NUM_W = MAG_W + 16;
	localparam int Q_W = 34;
	localparam int ACC_W = 43;

	localparam int FIFO_DEPTH = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_SINE     = 2'd0,
		CMD_SAW      = 2'd1,
		CMD_SQUARE   = 2'd2,
		CMD_TRIANGLE = 2'd3
	} wave_cmd_t;

	typedef struct packed {
		wave_cmd_t cmd;
		logic [PHASE_W-1:0] base;
	} phase_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage

/* design/fsws_if.sv */
// Valid/ready channel interfaces for request items and waveform sample items.
interface fsws_job_if import fsws_pkg::*; ();
	logic valid;
	logic ready;
	logic [CMD_W-1:0] command;
	logic [N_W-1:0] sample_index;
	logic [F_W-1:0] frequency_q8;

	modport source (output valid, command, sample_index, frequency_q8, input ready);
	modport sink (input valid, command, sample_index, frequency_q8, output ready);
endinterface

interface fsws_wave_if import fsws_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [OUT_W-1:0] wave_sample;

	modport source (output valid, wave_sample, input ready);
	modport sink (input valid, wave_sample, output ready);
endinterface

/* design/fsws_front.sv */
// Front end: accepts request items and computes the base phase by long division.
module fsws_front import fsws_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [FS_W-1:0]  sampling_rate,
	fsws_job_if.sink         job,
	input  fifo_status_t     fifo_st,
	output logic             push,
	output phase_job_t       push_data
);

	typedef enum logic [1:0] {F_IDLE, F_MUL, F_DIV, F_PUSH} fstate_t;

	fstate_t state_q;
	wave_cmd_t cmd_q;
	logic [N_W-1:0] n_q;
	logic [F_W-1:0] f_q;
	logic [DEN_W-1:0] d_q;
	logic [DIVIDEND_W-1:0] dvd_q;
	logic [DEN_W-1:0] rem_q;
	logic [PHASE_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic accept;
	logic [PROD_W-1:0] prod;
	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic [FS_W-1:0] fs_nz;

	assign job.ready = (state_q == F_IDLE);
	assign accept = job.valid && job.ready;
	assign push = (state_q == F_PUSH) && !fifo_st.full;
	assign push_data = '{cmd: cmd_q, base: quo_q};
	assign prod = f_q * n_q;
	assign trial = {rem_q, dvd_q[DIVIDEND_W-1]};
	assign diff = trial - {1'b0, d_q};
	assign fs_nz = (sampling_rate == '0) ? FS_W'(1) : sampling_rate;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) state_q <= F_MUL;
				end
				F_MUL: begin
					state_q <= F_DIV;
				end
				F_DIV: begin
					if (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push) state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= wave_cmd_t'(job.command);
			n_q <= job.sample_index;
			f_q <= job.frequency_q8;
			d_q <= {fs_nz, 8'b0};
		end
		if (state_q == F_MUL) begin
			dvd_q <= {prod, PHASE_W'(0)};
			rem_q <= '0;
			cnt_q <= '0;
		end else if (state_q == F_DIV) begin
			dvd_q <= dvd_q << 1;
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (trial >= {1'b0, d_q}) begin
				rem_q <= diff[DEN_W-1:0];
				quo_q <= {quo_q[PHASE_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[PHASE_W-2:0], 1'b0};
			end
		end
	end

endmodule

/* design/fsws_fifo.sv */
// Short queue of phase jobs between the front end and the harmonic engine.
module fsws_fifo import fsws_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  phase_job_t   push_data,
	input  logic         pop,
	output phase_job_t   pop_data,
	output fifo_status_t status
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	phase_job_t mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full = (count_q == CNT_W'(FIFO_DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

/* design/fsws_back.sv */
// Harmonic engine: sine lookup, weighting and accumulation, one harmonic per cycle.
module fsws_back import fsws_pkg::*; #(
	parameter int MAX_HARMONICS = DEF_MAX_HARMONICS,
	parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [HC_W-1:0] harmonic_count,
	input  fifo_status_t    fifo_st,
	input  phase_job_t      pop_data,
	output logic            pop,
	fsws_wave_if.source     wave
);

	localparam int IW_H = $clog2(MAX_HARMONICS + 3);
	localparam int CNT_W = (IW_H > HC_W) ? IW_H : HC_W;
	localparam int TI = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS + 1) : 1;
	localparam int WW = 2 * TI + 1;
	localparam int DW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int IPROD_W = 30 + DW;

	typedef enum logic [1:0] {B_IDLE, B_RUN, B_DRAIN, B_DONE} bstate_t;

	// Quarter-wave sine table and reciprocal tables, fixed at elaboration.
	logic [MAG_W-1:0] rom [SINE_TABLE_DEPTH+1];
	logic [RECIP_W-1:0] recip_lin [MAX_HARMONICS+1];
	logic [RECIP_W-1:0] recip_sq [MAX_HARMONICS+1];

	for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam logic [63:0] X = (64'(k) * PI_Q30) / (64'(2 * SINE_TABLE_DEPTH));
		localparam logic [63:0] X2 = (X * X) >> 30;
		localparam logic [63:0] T1 = ((X * X2) >> 30) / 64'd6;
		localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
		localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
		localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
		localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
		localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
		localparam logic [63:0] T7 = ((T6 * X2) >> 30) / 64'd210;
		localparam logic signed [63:0] S = $signed(X) - $signed(T1) + $signed(T2)
			- $signed(T3) + $signed(T4) - $signed(T5) + $signed(T6) - $signed(T7);
		localparam logic [63:0] SC = (S < 0) ? 64'd0 : $unsigned(S);
		localparam logic [63:0] ENTRY = (SC + 64'd8192) >> 14;
		assign rom[k] = ENTRY[MAG_W-1:0];
	end

	for (genvar h = 0; h <= MAX_HARMONICS; h++) begin : g_recip
		localparam logic [63:0] HL = (h == 0) ? 64'd1 : 64'(h);
		localparam logic [63:0] RL = (64'd1 << RECIP_SHIFT) / HL;
		localparam logic [63:0] RS = (64'd1 << RECIP_SHIFT) / (HL * HL);
		assign recip_lin[h] = RL[RECIP_W-1:0];
		assign recip_sq[h] = RS[RECIP_W-1:0];
	end

	bstate_t state_q;
	wave_cmd_t cmd_q;
	logic [PHASE_W-1:0] ph_q;
	logic [PHASE_W-1:0] inc_q;
	logic [IW_H-1:0] i_q;
	logic [IW_H-1:0] step_q;
	logic [IW_H-1:0] nmax_q;
	logic signed [ACC_W-1:0] acc_q;
	logic out_valid_q;
	logic signed [OUT_W-1:0] out_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [PHASE_W-1:0] ph_s1;
	logic [TI-1:0] i_s1, i_s2;
	logic tneg_s1, tneg_s2;
	logic [1:0] quad_s2;
	logic [IPROD_W-1:0] iprod_s2;
	logic [MAG_W-1:0] mag_s3;
	logic [RECIP_W-1:0] recip_s3;
	logic [WW-1:0] w_s3, w_s4, w_s5;
	logic neg_s3, neg_s4, neg_s5;
	logic [MAG_W+RECIP_W-1:0] mr_s4;
	logic [NUM_W-1:0] n_s4, n_s5;
	logic [Q_W-1:0] q0_s5;
	logic [Q_W:0] qw_s5;

	logic [CNT_W-1:0] hc_x;
	logic [CNT_W-1:0] nmax_full;
	logic [IW_H-1:0] nmax_sel;
	logic series_odd;
	logic issue;
	logic last;
	logic pipe_busy;
	logic load_out;
	logic [IPROD_W-1:0] iprod;
	logic [DW-1:0] idx_raw;
	logic [DW-1:0] idx;
	logic [MAG_W+RECIP_W-1:0] mr;
	logic [Q_W-1:0] q0;
	logic [Q_W+WW-1:0] qw;
	logic [Q_W:0] r;
	logic [Q_W-1:0] q;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] rsum;
	logic signed [ACC_W-1:0] res;
	logic signed [OUT_W-1:0] res_sat;

	assign hc_x = CNT_W'(harmonic_count);
	assign nmax_full = (hc_x > CNT_W'(MAX_HARMONICS)) ? CNT_W'(MAX_HARMONICS) : hc_x;
	assign nmax_sel = (pop_data.cmd == CMD_SINE) ? IW_H'(1) : nmax_full[IW_H-1:0];
	assign series_odd = (pop_data.cmd == CMD_SQUARE) || (pop_data.cmd == CMD_TRIANGLE);

	assign pop = (state_q == B_IDLE) && !fifo_st.empty;
	assign issue = (state_q == B_RUN);
	assign last = (i_q + step_q) > nmax_q;
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign load_out = (state_q == B_DONE) && (!out_valid_q || wave.ready);

	assign iprod = IPROD_W'(ph_s1[29:0]) * IPROD_W'(SINE_TABLE_DEPTH);
	assign idx_raw = iprod_s2[30 +: DW];
	assign idx = quad_s2[0] ? DW'(SINE_TABLE_DEPTH) - idx_raw : idx_raw;
	assign mr = mag_s3 * recip_s3;
	assign q0 = mr_s4[RECIP_SHIFT-16 +: Q_W];
	assign qw = q0 * w_s4;
	assign r = {2'b0, n_s5} - qw_s5;
	assign q = q0_s5 + Q_W'(r >= (Q_W+1)'(w_s5));
	assign term = neg_s5 ? -ACC_W'(q) : ACC_W'(q);

	assign rsum = acc_q + ACC_W'(32768);
	assign res = rsum >>> 16;
	always_comb begin
		if (res > ACC_W'(signed'(524287))) res_sat = OUT_W'(signed'(524287));
		else if (res < -ACC_W'(signed'(524288))) res_sat = OUT_W'(-signed'(524288));
		else res_sat = res[OUT_W-1:0];
	end

	assign wave.valid = out_valid_q;
	assign wave.wave_sample = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (load_out) out_valid_q <= 1'b1;
			else if (wave.ready) out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (pop) state_q <= (nmax_sel == '0) ? B_DRAIN : B_RUN;
				end
				B_RUN: begin
					if (last) state_q <= B_DRAIN;
				end
				B_DRAIN: begin
					if (!pipe_busy) state_q <= B_DONE;
				end
				B_DONE: begin
					if (load_out) state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= pop_data.cmd;
			ph_q <= pop_data.base;
			inc_q <= series_odd ? {pop_data.base[PHASE_W-2:0], 1'b0} : pop_data.base;
			step_q <= series_odd ? IW_H'(2) : IW_H'(1);
			i_q <= IW_H'(1);
			nmax_q <= nmax_sel;
			acc_q <= '0;
		end else begin
			if (issue) begin
				ph_q <= ph_q + inc_q;
				i_q <= i_q + step_q;
			end
			if (v_s5) acc_q <= acc_q + term;
		end

		ph_s1 <= ph_q;
		i_s1 <= i_q[TI-1:0];
		tneg_s1 <= i_q[1];

		quad_s2 <= ph_s1[31:30];
		iprod_s2 <= iprod;
		i_s2 <= i_s1;
		tneg_s2 <= tneg_s1;

		mag_s3 <= rom[idx];
		recip_s3 <= (cmd_q == CMD_TRIANGLE) ? recip_sq[i_s2] : recip_lin[i_s2];
		w_s3 <= (cmd_q == CMD_TRIANGLE) ? WW'(i_s2) * WW'(i_s2) : WW'(i_s2);
		neg_s3 <= quad_s2[1] ^ ((cmd_q == CMD_TRIANGLE) && tneg_s2);

		mr_s4 <= mr;
		n_s4 <= {mag_s3, 16'b0};
		w_s4 <= w_s3;
		neg_s4 <= neg_s3;

		q0_s5 <= q0;
		qw_s5 <= qw[Q_W:0];
		n_s5 <= n_s4;
		w_s5 <= w_s4;
		neg_s5 <= neg_s4;

		if (load_out) out_q <= res_sat;
	end

endmodule

/* design/fourier_series_waveform_synth.sv */
// Fourier-series waveform synthesizer: one Q3.16 sample per request item for sine,
// sawtooth, square or triangle. The front end takes a new item only when idle: it accepts
// the item, forms the frequency-by-index product, runs the 88-bit bit-serial division
// that yields the base phase, then hands the job to a two-entry queue while it is not full.
// The harmonic engine behind the queue sums one harmonic per cycle (harmonics 1 to N for
// sawtooth, the odd ones for square and triangle, the fundamental alone for sine), then
// drains its pipeline and loads the output; the result waits in an output register, so the
// front end keeps working while a sample is not yet taken.
module fourier_series_waveform_synth import fsws_pkg::*; #(
	parameter int MAX_HARMONICS = DEF_MAX_HARMONICS,
	parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FS_W-1:0]      cfg_wdata,
	fsws_job_if.sink             job,
	fsws_wave_if.source          wave
);

	logic [FS_W-1:0] sampling_rate_q;
	logic [HC_W-1:0] harmonic_count_q;

	logic push;
	logic pop;
	phase_job_t push_data;
	phase_job_t pop_data;
	fifo_status_t fifo_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sampling_rate_q <= FS_RESET;
			harmonic_count_q <= HC_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLING_RATE: sampling_rate_q <= cfg_wdata;
				REG_HARMONIC_COUNT: harmonic_count_q <= cfg_wdata[HC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fsws_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.sampling_rate (sampling_rate_q),
		.job           (job),
		.fifo_st       (fifo_st),
		.push          (push),
		.push_data     (push_data)
	);

	fsws_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (fifo_st)
	);

	fsws_back #(
		.MAX_HARMONICS    (MAX_HARMONICS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.harmonic_count (harmonic_count_q),
		.fifo_st        (fifo_st),
		.pop_data       (pop_data),
		.pop            (pop),
		.wave           (wave)
	);

`ifndef SYNTHESIS
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_st.full) else $error("Queue written while full.");
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_st.empty) else $error("Queue read while empty.");
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(job.valid && job.ready) |=> !job.ready) else $error("Front end took two items.");
`endif

endmodule

/* tb/fourier_series_waveform_synth_tb.sv */
// Self-checking testbench for the Fourier-series waveform synthesizer.
module fourier_series_waveform_synth_tb;
	import fsws_pkg::*;

	localparam int TABLE_DEPTH = DEF_SINE_TABLE_DEPTH;
	localparam int HARM_LIMIT = DEF_MAX_HARMONICS;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 200;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [FS_W-1:0] cfg_wdata;

	fsws_job_if job ();
	fsws_wave_if wave ();

	fourier_series_waveform_synth dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.job(job),
		.wave(wave)
	);

	logic signed [OUT_W-1:0] expected_samples[$];
	int quarter_sine[TABLE_DEPTH + 1];
	logic [FS_W-1:0] model_rate;
	logic [HC_W-1:0] model_harmonics;

	int error_count = 0;
	int samples_checked = 0;
	int items_by_cmd[4];
	int config_writes = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int hold_requests = 0;
	int hold_served = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic void build_quarter_sine();
		longint unsigned x, x2, term;
		longint sum;
		for (int k = 0; k <= TABLE_DEPTH; k++) begin
			x = (longint'(k) * PI_Q30) / (2 * TABLE_DEPTH);
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			for (int j = 1; j <= 7; j++) begin
				term = ((term * x2) >> 30) / longint'((2 * j) * (2 * j + 1));
				if (j % 2 == 1)
					sum -= longint'(term);
				else
					sum += longint'(term);
			end
			if (sum < 0)
				sum = 0;
			quarter_sine[k] = int'((unsigned'(sum) + 8192) >> 14);
		end
	endfunction

	function automatic int sine_of_phase(logic [PHASE_W-1:0] phase);
		int unsigned idx;
		int v;
		idx = int'((longint'(phase[29:0]) * TABLE_DEPTH) >> 30);
		if (phase[30])
			idx = TABLE_DEPTH - idx;
		v = quarter_sine[idx];
		return phase[31] ? -v : v;
	endfunction

	function automatic longint harmonic_term(int v, int unsigned w);
		longint unsigned mag;
		longint q;
		mag = (v < 0) ? longint'(-v) : longint'(v);
		q = longint'((mag << 16) / w);
		return (v < 0) ? -q : q;
	endfunction

	function automatic logic signed [OUT_W-1:0] synth_sample(wave_cmd_t cmd,
			logic [N_W-1:0] n, logic [F_W-1:0] f);
		longint unsigned rate, den, rem;
		logic [PHASE_W-1:0] base, phase;
		int unsigned top;
		longint acc, res, t;
		int v;
		rate = (model_rate == 0) ? 1 : model_rate;
		den = rate << 8;
		rem = (longint'(f) * longint'(n)) % den;
		base = PHASE_W'((rem << 32) / den);
		top = (model_harmonics > HARM_LIMIT) ? HARM_LIMIT : model_harmonics;
		acc = 0;
		if (cmd == CMD_SINE) begin
			res = sine_of_phase(base);
		end else begin
			for (int unsigned i = 1; i <= top; i++) begin
				if (cmd != CMD_SAW && i % 2 == 0)
					continue;
				phase = PHASE_W'(longint'(i) * base);
				v = sine_of_phase(phase);
				if (cmd == CMD_TRIANGLE) begin
					t = harmonic_term(v, i * i);
					acc += (i % 4 == 1) ? t : -t;
				end else begin
					acc += harmonic_term(v, i);
				end
			end
			res = (acc + 32768) >>> 16;
		end
		if (res > 524287)
			res = 524287;
		if (res < -524288)
			res = -524288;
		return OUT_W'(res);
	endfunction

	task automatic report_mismatch(string what, logic signed [OUT_W-1:0] got,
			logic signed [OUT_W-1:0] want);
		$display("Mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what,
			got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && wave.valid && wave.ready) begin
			if (expected_samples.size() == 0) begin
				report_mismatch("unexpected sample", wave.wave_sample, '0);
			end else begin
				if (wave.wave_sample !== expected_samples[0])
					report_mismatch("wave_sample", wave.wave_sample, expected_samples[0]);
				void'(expected_samples.pop_front());
				samples_checked++;
			end
		end
	end

	// Receiver: changing stall patterns, plus long hold-offs on request.
	int stall_mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			wave.ready = 1'b0;
		end else begin
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = 1500;
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(50, 400);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				wave.ready = 1'b0;
			end else begin
				case (stall_mode)
					0: wave.ready = 1'b1;
					1: wave.ready = ($urandom_range(0, 9) < 7);
					2: wave.ready = (cycle_count % 3 == 0);
					default: wave.ready = ($urandom_range(0, 9) < 2);
				endcase
			end
		end
	end

	task automatic send_item(wave_cmd_t cmd, logic [N_W-1:0] n, logic [F_W-1:0] f);
		@(negedge clk);
		if (burst_left == 0) begin
			job.valid = 1'b0;
			repeat ($urandom_range(0, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		job.valid = 1'b1;
		job.command = cmd;
		job.sample_index = n;
		job.frequency_q8 = f;
		do @(posedge clk); while (!job.ready);
		expected_samples.push_back(synth_sample(cmd, n, f));
		items_by_cmd[cmd]++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		job.valid = 1'b0;
		burst_left = 0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [FS_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_SAMPLING_RATE)
			model_rate = value;
		else if (idx == REG_HARMONIC_COUNT)
			model_harmonics = value[HC_W-1:0];
		config_writes++;
	endtask

	task automatic set_config(logic [FS_W-1:0] rate, logic [HC_W-1:0] harmonics);
		wait_drained();
		write_register(REG_SAMPLING_RATE, rate);
		write_register(REG_HARMONIC_COUNT,
			{(FS_W-HC_W)'($urandom_range(0, 2047)), harmonics});
	endtask

	function automatic logic [F_W-1:0] random_frequency();
		case ($urandom_range(0, 3))
			0: return F_W'($urandom);
			1: return F_W'($urandom_range(1, 256 * 2000));
			2: return F_W'($urandom_range(0, 255));
			default: return F_W'($urandom_range(256 * 20, 256 * 20000));
		endcase
	endfunction

	task automatic test_directed();
		for (int c = 0; c < 4; c++) begin
			send_item(wave_cmd_t'(c), 32'd0, 24'd0);
			send_item(wave_cmd_t'(c), 32'hFFFF_FFFF, 24'hFF_FFFF);
			send_item(wave_cmd_t'(c), 32'd1, F_W'(256 * 440));
			send_item(wave_cmd_t'(c), 32'd5, F_W'(256 * 1000));
			send_item(wave_cmd_t'(c), 32'hFFFF_FFFF, 24'd0);
		end
		send_item(CMD_SAW, 32'd3, F_W'(256 * 250));
		send_item(CMD_SQUARE, 32'd1, F_W'(256 * 250));
	endtask

	task automatic test_config_extremes();
		logic [FS_W-1:0] rates[6] = '{18'd1, 18'd0, 18'd192000, 18'h3FFFF, 18'd44100,
			18'd8000};
		logic [HC_W-1:0] counts[6] = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd2, 7'd50};
		for (int s = 0; s < 6; s++) begin
			set_config(rates[s], counts[s]);
			for (int c = 0; c < 4; c++)
				send_item(wave_cmd_t'(c), $urandom, random_frequency());
			send_item(CMD_SAW, $urandom_range(0, 100), F_W'(256 * 50));
		end
		// Writes to unused register indexes must leave the settings alone.
		wait_drained();
		write_register(2'd2, 18'd5);
		write_register(2'd3, 18'd7);
		for (int c = 0; c < 4; c++)
			send_item(wave_cmd_t'(c), $urandom, random_frequency());
	endtask

	task automatic test_random(int count);
		for (int k = 0; k < count; k++) begin
			if (k % 150 == 0)
				set_config($urandom_range(0, 3) == 0 ? FS_W'($urandom) :
					FS_W'($urandom_range(1, 192000)),
					$urandom_range(0, 3) == 0 ? HC_W'($urandom) : HC_W'($urandom_range(1, 64)));
			send_item(wave_cmd_t'($urandom_range(0, 3)), $urandom, random_frequency());
		end
	endtask

	task automatic test_backpressure();
		wait_drained();
		hold_requests++;
		for (int k = 0; k < 12; k++)
			send_item(wave_cmd_t'($urandom_range(0, 3)), $urandom, random_frequency());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		job.valid = 1'b0;
		job.command = '0;
		job.sample_index = '0;
		job.frequency_q8 = '0;
		wave.ready = 1'b0;
		model_rate = FS_RESET;
		model_harmonics = HC_RESET;
		build_quarter_sine();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_config_extremes();
		test_backpressure();
		test_random(1050);
		test_backpressure();
		wait_drained();

		$display("Checked %0d samples: sine %0d, sawtooth %0d, square %0d, triangle %0d.",
			samples_checked, items_by_cmd[0], items_by_cmd[1], items_by_cmd[2],
			items_by_cmd[3]);
		$display("%0d register writes, %0d receiver hold-offs, %0d mismatches.",
			config_writes, hold_requests, error_count);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
design/fsws_pkg.sv
design/fsws_if.sv
design/fsws_front.sv
design/fsws_fifo.sv
design/fsws_back.sv
design/fourier_series_waveform_synth.sv
tb/fourier_series_waveform_synth_tb.sv
